>>> sv/bur_pkg.sv
// Shared types and codes for the bounded undo/redo history block.
// Used by the controller, the output register and the top level; no dependencies.
package bur_pkg;

	typedef enum logic [2:0] {
		ACT_PUSH  = 3'd0,
		ACT_UNDO  = 3'd1,
		ACT_REDO  = 3'd2,
		ACT_GOTO  = 3'd3,
		ACT_CLEAR = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_EXEC = 2'd1,
		OP_UNDO = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	// Everything of one result except the handle, whose width is a parameter.
	typedef struct packed {
		op_t         operation;
		logic [6:0]  cursor_after;
		logic [6:0]  length_after;
		logic        undo_possible;
		logic        redo_possible;
		logic        changed;
		logic        last;
	} res_t;

	localparam logic [6:0] MAX_DEPTH_RESET = 7'd64;
	localparam logic [6:0] CURSOR_NONE     = 7'h7F;

endpackage

>>> sv/bur_store.sv
// Ring store of command handles: one write port and one registered read port.
// Depends on nothing; the controller makes sure reads and writes never meet.
module bur_store #(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [HANDLE_BITS-1:0]   wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [HANDLE_BITS-1:0]   rd_data
);

	logic [HANDLE_BITS-1:0] mem [DEPTH];
	logic [HANDLE_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/bur_outreg.sv
// Output register of the result channel; holds one result while the receiver stalls.
// Depends on bur_pkg for the result struct.
module bur_outreg
	import bur_pkg::*;
#(
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  res_t                   res,
	input  logic [HANDLE_BITS-1:0] res_handle,
	output logic                   free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output res_t                   out_res,
	output logic [HANDLE_BITS-1:0] out_handle
);

	logic                   valid_q;
	res_t                   res_q;
	logic [HANDLE_BITS-1:0] handle_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q    <= res;
			handle_q <= res_handle;
		end
	end

	assign out_valid  = valid_q;
	assign out_res    = res_q;
	assign out_handle = handle_q;

endmodule

>>> sv/bur_ctrl.sv
// Sequencer of the history: holds cursor, length and oldest slot, drives the store
// and produces results. Depends on bur_pkg.
module bur_ctrl
	import bur_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               in_action,
	input  logic [HANDLE_BITS-1:0]   in_handle,
	input  logic [6:0]               in_target,
	input  logic [6:0]               max_depth,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [HANDLE_BITS-1:0]   wr_data,
	output logic                     rd_en,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [HANDLE_BITS-1:0]   rd_data,
	input  logic                     out_free,
	output logic                     res_load,
	output res_t                     res,
	output logic [HANDLE_BITS-1:0]   res_handle
);

	localparam int SW = $clog2(DEPTH);
	localparam logic [7:0] DEPTH8 = 8'(DEPTH);
	localparam logic [6:0] DEPTH7 = 7'(DEPTH);
	localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);

	state_t state_q, state_d;

	logic [2:0]             act_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [6:0]             tgt_q;
	logic [SW-1:0]          oldest_q;
	logic [6:0]             count_q;
	logic [6:0]             cursor_q;
	op_t                    pend_op_q;
	logic                   pend_last_q;

	logic signed [7:0] cur8, top8, tgt8, tc8, cnt_new8;
	logic [6:0]        limit;

	// Decision of the EXEC cycle.
	logic          want_read;
	logic [6:0]    read_idx;
	logic [6:0]    read_cursor;
	op_t           read_op;
	logic          read_last;
	op_t           imm_op;
	logic          imm_changed;
	logic [6:0]    imm_cursor;
	logic [6:0]    imm_count;
	logic [SW-1:0] imm_oldest;

	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
	                                          input logic [6:0] idx);
		logic [7:0] sum;
		sum = 8'(base) + {1'b0, idx};
		if (sum >= DEPTH8) begin
			sum = sum - DEPTH8;
		end
		return sum[SW-1:0];
	endfunction

	function automatic logic redo_ok(input logic [6:0] c, input logic [6:0] n);
		logic signed [7:0] c8, top;
		c8  = {c[6], c};
		top = $signed({1'b0, n}) - 8'sd1;
		return c8 < top;
	endfunction

	assign cur8 = {cursor_q[6], cursor_q};
	assign top8 = $signed({1'b0, count_q}) - 8'sd1;
	assign tgt8 = {tgt_q[6], tgt_q};
	assign tc8  = (tgt8 < -8'sd1) ? -8'sd1 : ((tgt8 > top8) ? top8 : tgt8);
	assign cnt_new8 = cur8 + 8'sd2;

	always_comb begin
		if (max_depth == 7'd0) begin
			limit = 7'd1;
		end else if (max_depth > DEPTH7) begin
			limit = DEPTH7;
		end else begin
			limit = max_depth;
		end
	end

	always_comb begin
		want_read   = 1'b0;
		read_idx    = cursor_q;
		read_cursor = cursor_q;
		read_op     = OP_UNDO;
		read_last   = 1'b1;
		imm_op      = OP_NONE;
		imm_changed = 1'b0;
		imm_cursor  = cursor_q;
		imm_count   = count_q;
		imm_oldest  = oldest_q;
		case (act_q)
			ACT_PUSH: begin
				imm_op      = OP_EXEC;
				imm_changed = 1'b1;
				// The new entry goes just above the cursor; anything above it is gone.
				if (cnt_new8 > $signed({1'b0, limit})) begin
					imm_oldest = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
					imm_count  = 7'(cnt_new8 - 8'sd1);
					imm_cursor = cursor_q;
				end else begin
					imm_count  = 7'(cnt_new8);
					imm_cursor = 7'(cur8 + 8'sd1);
				end
			end
			ACT_UNDO: begin
				if (!cursor_q[6]) begin
					want_read   = 1'b1;
					read_cursor = 7'(cur8 - 8'sd1);
				end
			end
			ACT_REDO: begin
				if (cur8 < top8) begin
					want_read   = 1'b1;
					read_idx    = 7'(cur8 + 8'sd1);
					read_cursor = 7'(cur8 + 8'sd1);
					read_op     = OP_EXEC;
				end
			end
			ACT_GOTO: begin
				if (cur8 > tc8) begin
					want_read   = 1'b1;
					read_cursor = 7'(cur8 - 8'sd1);
					read_last   = (cur8 - 8'sd1) == tc8;
				end else if (cur8 < tc8) begin
					want_read   = 1'b1;
					read_idx    = 7'(cur8 + 8'sd1);
					read_cursor = 7'(cur8 + 8'sd1);
					read_op     = OP_EXEC;
					read_last   = (cur8 + 8'sd1) == tc8;
				end
			end
			ACT_CLEAR: begin
				imm_changed = 1'b1;
				imm_cursor  = CURSOR_NONE;
				imm_count   = 7'd0;
				imm_oldest  = '0;
			end
			default: begin
				imm_op = OP_NONE;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (want_read) begin
					state_d = ST_READ;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (out_free) begin
					state_d = pend_last_q ? ST_IDLE : ST_EXEC;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready   = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		res_load   = 1'b0;
		res_handle = '0;
		res.operation     = OP_NONE;
		res.cursor_after  = cursor_q;
		res.length_after  = count_q;
		res.changed       = 1'b0;
		res.last          = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_EXEC: begin
				rd_en = want_read;
				if (!want_read) begin
					wr_en            = out_free && (act_q == ACT_PUSH);
					res_load         = out_free;
					res.operation    = imm_op;
					res.cursor_after = imm_cursor;
					res.length_after = imm_count;
					res.changed      = imm_changed;
					res_handle       = (act_q == ACT_PUSH) ? hnd_q : '0;
				end
			end
			ST_READ: begin
				// The cursor has already moved; the read data is the stepped entry.
				res_load      = out_free;
				res.operation = pend_op_q;
				res.changed   = 1'b1;
				res.last      = pend_last_q;
				res_handle    = rd_data;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		res.undo_possible = !res.cursor_after[6];
		res.redo_possible = redo_ok(res.cursor_after, res.length_after);
	end

	assign wr_addr = slot_of(oldest_q, 7'(cur8 + 8'sd1));
	assign wr_data = hnd_q;
	assign rd_addr = slot_of(oldest_q, read_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			count_q  <= 7'd0;
			cursor_q <= CURSOR_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				if (want_read) begin
					cursor_q <= read_cursor;
				end else if (out_free) begin
					cursor_q <= imm_cursor;
					count_q  <= imm_count;
					oldest_q <= imm_oldest;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			act_q <= in_action;
			hnd_q <= in_handle;
			tgt_q <= in_target;
		end
		if (state_q == ST_EXEC && want_read) begin
			pend_op_q   <= read_op;
			pend_last_q <= read_last;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH7)
		else $error("history length above store depth");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur8 >= -8'sd1) && (cur8 < $signed({1'b0, count_q})))
		else $error("cursor outside the held entries");

	a_read_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && want_read) |=> (state_q == ST_READ))
		else $error("store read not followed by its result cycle");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en)
		else $error("store read and write in the same cycle");

	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (res_load && res.operation == OP_EXEC && res.last))
		else $error("push stored without its execute result");

endmodule

>>> sv/bounded_undo_redo_history.sv
// Top level of the bounded undo/redo history: stream channels, configuration port,
// store, controller and output register. Depends on bur_pkg and the bur_* modules.
//
// Input items arrive on s_tvalid/s_tready/s_tdata and carry an action (push, undo,
// redo, goto, clear), a command handle and a goto target. Each item yields one or
// more result items on m_tvalid/m_tready/m_tdata, with m_tlast on the final one.
// max_depth is written through the APB port at address 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// An item is taken in the idle state and decided in the execute state. Push, clear,
// ignored actions and undo, redo or goto with nothing to do put their result in the
// output register from the execute state. Undo, redo and every goto step that moves
// the cursor read the ring store, whose read port is registered, so each such result
// is loaded from a read state after its execute state; a goto repeats both per step.
// One item is worked on at a time; the next is accepted once the last result of
// the previous one has been loaded into the output register.
// A stalled receiver holds the output register and the sequencer waits for it.
// Reset empties the history (length 0, cursor -1) and sets max_depth to 64; the
// store itself is not cleared, since only written entries are ever read.
module bounded_undo_redo_history
	import bur_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata from bit 0: action[3], command_handle[HANDLE_BITS], target_index[7], zeros.
	input  logic [((HANDLE_BITS+10+7)/8)*8-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata from bit 0: operation[2], handle_out[HANDLE_BITS], cursor_after[7],
	// length_after[7], undo_possible, redo_possible, changed, zeros.
	output logic [((HANDLE_BITS+19+7)/8)*8-1:0] m_tdata,
	output logic                  m_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int SW    = $clog2(DEPTH);
	localparam int OUT_W = ((HANDLE_BITS + 19 + 7) / 8) * 8;

	logic [6:0] max_depth_q;

	logic                   wr_en, rd_en;
	logic [SW-1:0]          wr_addr, rd_addr;
	logic [HANDLE_BITS-1:0] wr_data, rd_data;
	logic                   out_free, res_load;
	res_t                   res, out_res;
	logic [HANDLE_BITS-1:0] res_handle, out_handle;

	// Only one register; the upper address bit selects space beyond it.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {25'd0, max_depth_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= MAX_DEPTH_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			max_depth_q <= pwdata[6:0];
		end
	end

	bur_store #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bur_ctrl #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tdata[2:0]),
		.in_handle  (s_tdata[3 +: HANDLE_BITS]),
		.in_target  (s_tdata[3 + HANDLE_BITS +: 7]),
		.max_depth  (max_depth_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_free   (out_free),
		.res_load   (res_load),
		.res        (res),
		.res_handle (res_handle)
	);

	bur_outreg #(
		.HANDLE_BITS (HANDLE_BITS)
	) u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (res_load),
		.res        (res),
		.res_handle (res_handle),
		.free       (out_free),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (out_res),
		.out_handle (out_handle)
	);

	assign m_tdata = OUT_W'({out_res.changed, out_res.redo_possible, out_res.undo_possible,
		out_res.length_after, out_res.cursor_after, out_handle, out_res.operation});
	assign m_tlast = out_res.last;

endmodule
